>>> rtl/fht_pkg.sv
// Shared constants and types for the frequency hit table.
package fht_pkg;

	localparam int unsigned TableSlots = 64;
	localparam int unsigned IdxW = $clog2(TableSlots);
	localparam int unsigned FillW = IdxW + 1;
	localparam int unsigned FreqW = 33;
	localparam int unsigned TolW = 20;
	localparam int unsigned HitsW = 16;
	localparam int unsigned OutIdxW = 6;
	// Width of freq * hits + freq before the division.
	localparam int unsigned ProdW = FreqW + HitsW + 1;

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_BAN = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;

	localparam logic CFG_MATCH_TOL = 1'b0;
	localparam logic CFG_BAN_TOL = 1'b1;

	localparam logic [TolW-1:0] MATCH_TOL_RESET = TolW'(5000);
	localparam logic [TolW-1:0] BAN_TOL_RESET = TolW'(10000);
	localparam logic [HitsW-1:0] HITS_MAX = '1;
	localparam logic [FreqW:0] ROUND_STEP = (FreqW+1)'(10000);
	localparam logic [FreqW-1:0] SKIP_SAT = FreqW'(64'd8589930000);

	typedef logic [FreqW-1:0] freq_t;
	typedef logic [HitsW-1:0] hits_t;
	typedef logic [TolW-1:0] tol_t;

	// Divider handshake between the sequencer and the divider.
	typedef struct packed {
		logic start;
		logic [ProdW-1:0] dividend;
		logic [HitsW:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [ProdW-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/fht_ram.sv
// Generic single-port RAM with a registered read.
module fht_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/fht_div.sv
// Restoring divider, one quotient bit per cycle.
module fht_div (
	input logic clk,
	input logic arst_n,
	input fht_pkg::div_req_t req,
	output fht_pkg::div_rsp_t rsp
);

	localparam int unsigned NW = fht_pkg::ProdW;
	localparam int unsigned DW = fht_pkg::HitsW + 1;
	localparam int unsigned CW = $clog2(NW + 1);

	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic done_q;
	logic [DW:0] trial;

	assign trial = {rem_q, quo_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= DW'(trial - {1'b0, dsr_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("divider done held for two cycles");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q))
		else $error("divider done without a run");
`endif

endmodule

>>> rtl/frequency_hit_table_unit.sv
// Top level of the frequency hit table: sequencer, tables and shared compare.
//
// Channel | Direction | Payload
// in      | to block  | op, freq
// out     | from blk  | result_freq, flag, entry_index, entry_count
// cfg     | to block  | cfg_index, cfg_data
//
// A table is scanned one entry at a time, each with a RAM read state and then a compare state;
// a ban adds a clear state per cleared entry, and a banned check adds the SK1 and SK2 states.
// A record merge adds MRD, MWAIT, MUL, DIV and DWAIT, which waits on the bit-serial divider.
// in_ready is high only while the sequencer is idle and the output register is empty.
// The output register holds a result until it is taken; no new item starts before then.
// Reset clears the fill counts and sets the tolerances to their reset values; table contents need no clearing.
module frequency_hit_table_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] op,
	input logic [fht_pkg::FreqW-1:0] freq,
	output logic out_valid,
	input logic out_ready,
	output logic [fht_pkg::FreqW-1:0] result_freq,
	output logic flag,
	output logic [fht_pkg::OutIdxW-1:0] entry_index,
	output logic [fht_pkg::HitsW-1:0] entry_count,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [fht_pkg::TolW-1:0] cfg_data
);

	localparam int unsigned IW = fht_pkg::IdxW;
	localparam int unsigned FW = fht_pkg::FreqW;
	localparam int unsigned HW = fht_pkg::HitsW;
	localparam int unsigned LW = fht_pkg::FillW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD = 4'd1;
	localparam logic [3:0] ST_CMP = 4'd2;
	localparam logic [3:0] ST_MRD = 4'd3;
	localparam logic [3:0] ST_MWAIT = 4'd4;
	localparam logic [3:0] ST_DIV = 4'd5;
	localparam logic [3:0] ST_DWAIT = 4'd6;
	localparam logic [3:0] ST_ROUND = 4'd7;
	localparam logic [3:0] ST_MUL = 4'd8;
	localparam logic [3:0] ST_BCLR = 4'd9;
	localparam logic [3:0] ST_SK1 = 4'd10;
	localparam logic [3:0] ST_SK2 = 4'd11;

	// 2^17 mod 10000, and a reciprocal of 10000 that is exact for any 28-bit value.
	localparam logic [10:0] Pow17Mod = 11'd1072;
	localparam logic [28:0] SkipRecip = 29'd439804652;

	logic [3:0] state_q;
	logic [1:0] op_q;
	fht_pkg::freq_t f_q;
	fht_pkg::tol_t mtol_q, btol_q;
	logic [LW-1:0] sfill_q, bfill_q;
	logic [IW-1:0] idx_q, best_q;
	logic found_q;
	fht_pkg::freq_t bestd_q;
	logic ovalid_q;
	fht_pkg::freq_t orf_q;
	logic oflag_q;
	logic [IW-1:0] oidx_q;
	fht_pkg::hits_t ocnt_q;
	logic [fht_pkg::ProdW-1:0] prod_q;
	fht_pkg::hits_t h_q;
	logic [FW:0] skip_q;
	logic [27:0] red_q;
	logic [13:0] qr_q;
	logic bdone_q;

	// Memories
	logic sf_we, sh_we, bf_we;
	logic [IW-1:0] s_addr, b_addr;
	fht_pkg::freq_t sf_wd, sf_rd, bf_rd;
	fht_pkg::hits_t sh_wd, sh_rd;

	fht_ram #(.Width(FW), .Depth(fht_pkg::TableSlots)) u_sfreq (
		.clk(clk), .we(sf_we), .addr(s_addr), .wdata(sf_wd), .rdata(sf_rd));
	fht_ram #(.Width(HW), .Depth(fht_pkg::TableSlots)) u_shits (
		.clk(clk), .we(sh_we), .addr(s_addr), .wdata(sh_wd), .rdata(sh_rd));
	fht_ram #(.Width(FW), .Depth(fht_pkg::TableSlots)) u_bfreq (
		.clk(clk), .we(bf_we), .addr(b_addr), .wdata(freq), .rdata(bf_rd));

	fht_pkg::div_req_t dreq;
	fht_pkg::div_rsp_t drsp;
	fht_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Shared window compare against whichever table is scanned.
	fht_pkg::freq_t cmp_s;
	fht_pkg::tol_t cmp_t;
	logic [FW:0] lo_sum, hi_sum;
	logic hit;
	fht_pkg::freq_t cmp_dist;
	assign cmp_s = (op_q == fht_pkg::OP_CHECK) ? bf_rd : sf_rd;
	assign cmp_t = (op_q == fht_pkg::OP_RECORD) ? mtol_q : btol_q;
	assign lo_sum = {1'b0, f_q} + {{(FW+1-fht_pkg::TolW){1'b0}}, cmp_t};
	assign hi_sum = {1'b0, cmp_s} + {{(FW+1-fht_pkg::TolW){1'b0}}, cmp_t};
	assign hit = (lo_sum >= {1'b0, cmp_s}) && ({1'b0, f_q} < hi_sum);
	assign cmp_dist = (f_q >= cmp_s) ? (f_q - cmp_s) : (cmp_s - f_q);

	logic [LW-1:0] scan_fill;
	logic last;
	assign scan_fill = (op_q == fht_pkg::OP_CHECK) ? bfill_q : sfill_q;
	assign last = ({1'b0, idx_q} + 1'b1) >= scan_fill;

	// A record scans fully; a ban scan also clears hit counts on the fly.
	assign in_ready = (state_q == ST_IDLE) && !ovalid_q;
	assign cfg_ready = 1'b1;

	logic [FW:0] sum_rnd;
	assign sum_rnd = {1'b0, f_q} + {{(FW-fht_pkg::TolW){1'b0}}, btol_q, 1'b0}
		+ fht_pkg::ROUND_STEP - 1'b1;

	// Skip frequency: sum_rnd minus its remainder modulo 10000, reduced in the SK1 and SK2 states.
	logic [55:0] red_prod;
	logic [27:0] red_back;
	logic [27:0] red_rem;
	logic [FW:0] skip_val;
	assign red_prod = {28'd0, red_q} * {27'd0, SkipRecip};
	assign red_back = {14'd0, qr_q} * fht_pkg::ROUND_STEP[27:0];
	assign red_rem = red_q - red_back;
	assign skip_val = skip_q - {{(FW+1-28){1'b0}}, red_rem};

	always_comb begin
		sf_we = 1'b0;
		sh_we = 1'b0;
		bf_we = 1'b0;
		s_addr = idx_q;
		b_addr = idx_q;
		sf_wd = f_q;
		sh_wd = fht_pkg::HitsW'(1);
		dreq.start = 1'b0;
		dreq.dividend = prod_q;
		dreq.divisor = {1'b0, h_q} + 1'b1;
		case (state_q)
			ST_IDLE: begin
				// The ban list entry is written at the transfer itself.
				if (in_valid && in_ready && op == fht_pkg::OP_BAN &&
					bfill_q < LW'(fht_pkg::TableSlots)) begin
					bf_we = 1'b1;
					b_addr = bfill_q[IW-1:0];
				end
			end
			ST_MRD: s_addr = best_q;
			ST_MWAIT: s_addr = best_q;
			ST_DIV: dreq.start = 1'b1;
			ST_DWAIT: begin
				s_addr = best_q;
				if (drsp.done) begin
					sf_we = 1'b1;
					sh_we = 1'b1;
					sf_wd = drsp.quotient[FW-1:0];
					sh_wd = (h_q == fht_pkg::HITS_MAX) ? h_q : h_q + 1'b1;
				end
			end
			ST_BCLR: begin
				s_addr = best_q;
				sh_we = 1'b1;
				sh_wd = '0;
			end
			ST_ROUND: begin
				if (op_q == fht_pkg::OP_RECORD) begin
					s_addr = sfill_q[IW-1:0];
					sf_we = 1'b1;
					sh_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mtol_q <= fht_pkg::MATCH_TOL_RESET;
			btol_q <= fht_pkg::BAN_TOL_RESET;
			sfill_q <= '0;
			bfill_q <= '0;
			ovalid_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == fht_pkg::CFG_MATCH_TOL) mtol_q <= cfg_data;
				else btol_q <= cfg_data;
			end
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						idx_q <= '0;
						found_q <= 1'b0;
						if (op == fht_pkg::OP_RECORD) begin
							state_q <= (sfill_q == '0) ? ST_ROUND : ST_RD;
						end else if (op == fht_pkg::OP_BAN) begin
							if (bfill_q >= LW'(fht_pkg::TableSlots)) begin
								state_q <= ST_ROUND;
							end else begin
								bfill_q <= bfill_q + 1'b1;
								state_q <= (sfill_q == '0) ? ST_ROUND : ST_RD;
							end
						end else if (op == fht_pkg::OP_CHECK) begin
							state_q <= (bfill_q == '0) ? ST_ROUND : ST_RD;
						end else begin
							state_q <= ST_ROUND;
						end
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					if (op_q == fht_pkg::OP_BAN && hit) begin
						state_q <= ST_BCLR;
					end else if (op_q == fht_pkg::OP_CHECK && hit) begin
						found_q <= 1'b1;
						state_q <= ST_SK1;
					end else if (last) begin
						state_q <= (op_q == fht_pkg::OP_RECORD && (found_q ||
							(hit && cmp_t != '0))) ? ST_MRD : ST_ROUND;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
					if (op_q == fht_pkg::OP_RECORD && hit && (!found_q || cmp_dist < bestd_q))
					begin
						found_q <= 1'b1;
					end
				end
				ST_BCLR: begin
					if (last) begin
						state_q <= ST_ROUND;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SK1: state_q <= ST_SK2;
				ST_SK2: state_q <= ST_ROUND;
				ST_MRD: state_q <= ST_MWAIT;
				ST_MWAIT: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (drsp.done) begin
						ovalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ROUND: begin
					if (op_q == fht_pkg::OP_RECORD) begin
						sfill_q <= (sfill_q + 1'b1 >= LW'(fht_pkg::TableSlots)) ? '0
							: sfill_q + 1'b1;
					end
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= op;
				f_q <= freq;
			end
			ST_CMP: begin
				if (op_q == fht_pkg::OP_RECORD && hit && (!found_q || cmp_dist < bestd_q))
				begin
					best_q <= idx_q;
					bestd_q <= cmp_dist;
				end
				if (op_q == fht_pkg::OP_BAN) best_q <= idx_q;
				skip_q <= sum_rnd;
			end
			// Folding the high half by 2^17 mod 10000 keeps the remainder modulo 10000.
			ST_SK1: red_q <= {11'd0, skip_q[FW:17]} * {17'd0, Pow17Mod}
				+ {11'd0, skip_q[16:0]};
			ST_SK2: qr_q <= red_prod[55:42];
			ST_MWAIT: h_q <= sh_rd;
			ST_MUL: prod_q <= sf_rd * h_q + {{(fht_pkg::ProdW-FW){1'b0}}, f_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			orf_q <= f_q;
			oflag_q <= 1'b0;
			oidx_q <= '0;
			ocnt_q <= '0;
			case (op_q)
				fht_pkg::OP_RECORD: begin
					oidx_q <= sfill_q[IW-1:0];
					ocnt_q <= fht_pkg::HitsW'(1);
				end
				fht_pkg::OP_BAN: oflag_q <= (bfill_q != '0) && !found_q && bdone_q;
				fht_pkg::OP_CHECK: begin
					if (found_q) begin
						oflag_q <= 1'b1;
						orf_q <= (skip_val > {1'b0, fht_pkg::SKIP_SAT}) ?
							fht_pkg::SKIP_SAT : skip_val[FW-1:0];
					end
				end
				default: orf_q <= '0;
			endcase
		end else if (state_q == ST_DWAIT && drsp.done) begin
			orf_q <= drsp.quotient[FW-1:0];
			oflag_q <= 1'b1;
			oidx_q <= best_q;
			ocnt_q <= sh_wd;
		end
	end

	// Ban accepted marker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bdone_q <= 1'b0;
		end else if (state_q == ST_IDLE && in_valid && in_ready) begin
			bdone_q <= (op == fht_pkg::OP_BAN) && (bfill_q < LW'(fht_pkg::TableSlots));
		end
	end

	assign out_valid = ovalid_q;
	assign result_freq = orf_q;
	assign flag = oflag_q;
	assign entry_index = fht_pkg::OutIdxW'(oidx_q);
	assign entry_count = ocnt_q;

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		sfill_q < LW'(fht_pkg::TableSlots))
		else $error("saved fill out of range");
	a_ban_range: assert property (@(posedge clk) disable iff (!arst_n)
		bfill_q <= LW'(fht_pkg::TableSlots))
		else $error("ban fill out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input ready while busy");
`endif

endmodule
